@@ design/csib_pkg.sv @@
// shared constants, types and helpers for the cross stencil image blur core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package csib_pkg;

    localparam int MaxWidth  = 128;
    localparam int MaxHeight = 128;

    localparam int COL_W = $clog2(MaxWidth);
    localparam int ROW_W = $clog2(MaxHeight);
    localparam int PIX_W = 8;
    localparam int CFG_W = 8;
    localparam int IDX_W = 8;

    // five 8-bit terms plus rounding
    localparam int SUM_W = PIX_W + 3;

    // floor(x / 5) == (x * DIV5_RECIP) >> DIV5_SHIFT for x below 16384
    localparam int DIV5_RECIP = 13108;
    localparam int DIV5_SHIFT = 16;
    localparam int RECIP_W    = 14;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = IDX_W'(1);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last_of_run;
        logic             frame_end;
    } csib_result_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] col_right;
    } csib_lb_rd_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
    } csib_lb_wr_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] r;
        begin
            if (v == '0)
                r = CFG_W'(1);
            else if (v > maxv)
                r = maxv;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

@@ design/cross_stencil_image_blur_core.sv @@
// top level of the cross stencil image blur: counters, stencil pipeline and ports
// depends on csib_pkg, csib_line_buf and csib_res_fifo
`timescale 1ns / 1ps

// Five-point cross blur over a raster-order 8-bit grayscale stream. Frame size
// comes from two registers (index 0 width, index 1 height, 1..128; 0 acts as 1,
// larger values as 128); any write to them restarts the frame, so write them only
// while the block is idle. Pixels are accepted one per clock while the result queue
// has room for their results. For input (r,c) with r >= 1 the block returns pixel
// (r-1,c); border pixels pass through and interior pixels become the rounded mean
// of the cross. On the last row each item also returns (r,c), so there the output
// port, at one result per clock, limits the rate at which items are accepted. A
// result passes line-buffer read and summing, then division by five, before it is
// queued; an eight-entry result queue decouples the output handshake from the input.

module cross_stencil_image_blur_core
    import csib_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] pixel_in,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic [PIX_W-1:0] out_value,
    output logic             last_of_run,
    output logic             frame_end,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;

    logic in_acc;
    logic cfg_acc;
    logic cfg_hit;
    logic last_row;
    logic last_col;
    logic has_prev;
    logic interior;

    // stage 1: line-buffer data valid
    logic             s1_valid_reg;
    logic [1:0]       s1_n_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_prev_reg;
    logic             s1_last_row_reg;
    logic             s1_last_col_reg;
    logic             s1_interior_reg;
    logic [PIX_W-1:0] left_above_reg;
    logic [SUM_W-1:0] s1_sum;

    // stage 2: divide and push
    logic             s2_valid_reg;
    logic [1:0]       s2_n_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [PIX_W-1:0] s2_pix_reg;
    logic [PIX_W-1:0] s2_above_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_prev_reg;
    logic             s2_last_row_reg;
    logic             s2_last_col_reg;
    logic             s2_interior_reg;
    logic [PROD_W-1:0] div_prod;
    logic [PIX_W-1:0] s2_value;

    csib_lb_rd_t      lb_rd;
    csib_lb_wr_t      lb_wr;
    logic [PIX_W-1:0] lb_above;
    logic [PIX_W-1:0] lb_up;
    logic [PIX_W-1:0] lb_right;

    csib_result_t       res_prev;
    csib_result_t       res_cur;
    csib_result_t       push0;
    csib_result_t       push1;
    csib_result_t       head;
    logic [1:0]         push_cnt;
    logic [FIFO_CW-1:0] fifo_count;
    logic [FIFO_CW+1:0] reserved;

    assign w_eff = clamp_size(width_reg, CFG_W'(MaxWidth));
    assign h_eff = clamp_size(height_reg, CFG_W'(MaxHeight));

    assign reserved = (FIFO_CW+2)'(fifo_count) + (FIFO_CW+2)'(s1_n_reg)
                    + (FIFO_CW+2)'(s2_n_reg) + (FIFO_CW+2)'(2);
    assign in_ready  = (reserved <= (FIFO_CW+2)'(FIFO_DEPTH));
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == CFG_IDX_WIDTH) || (cfg_index == CFG_IDX_HEIGHT);

    assign last_row = (CFG_W'(row_reg) + CFG_W'(1)) == h_eff;
    assign last_col = (CFG_W'(col_reg) + CFG_W'(1)) == w_eff;
    assign has_prev = (row_reg != '0);
    assign interior = (row_reg >= ROW_W'(2)) && (col_reg != '0)
                   && ((CFG_W'(col_reg) + CFG_W'(1)) < w_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_acc && cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : ROW_W'(row_reg + ROW_W'(1));
            end
            else
            begin
                col_next = COL_W'(col_reg + COL_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_W'(MaxWidth);
            height_reg   <= CFG_W'(MaxHeight);
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_n_reg     <= '0;
            s2_valid_reg <= 1'b0;
            s2_n_reg     <= '0;
        end
        else
        begin
            if (cfg_acc && (cfg_index == CFG_IDX_WIDTH))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_acc && (cfg_index == CFG_IDX_HEIGHT))
            begin
                height_reg <= cfg_data;
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= in_acc;
            s1_n_reg     <= in_acc ? 2'(has_prev) + 2'(last_row) : 2'd0;
            s2_valid_reg <= s1_valid_reg;
            s2_n_reg     <= s1_n_reg;
        end
    end

    // item context travels beside the memory read
    always_ff @(posedge clk)
    begin
        s1_row_reg      <= row_reg;
        s1_col_reg      <= col_reg;
        s1_pix_reg      <= pixel_in;
        s1_prev_reg     <= has_prev;
        s1_last_row_reg <= last_row;
        s1_last_col_reg <= last_col;
        s1_interior_reg <= interior;
        if (s1_valid_reg)
        begin
            left_above_reg <= lb_above;
        end
        s2_row_reg      <= s1_row_reg;
        s2_col_reg      <= s1_col_reg;
        s2_pix_reg      <= s1_pix_reg;
        s2_above_reg    <= lb_above;
        s2_sum_reg      <= s1_sum;
        s2_prev_reg     <= s1_prev_reg;
        s2_last_row_reg <= s1_last_row_reg;
        s2_last_col_reg <= s1_last_col_reg;
        s2_interior_reg <= s1_interior_reg;
    end

    assign lb_rd.valid     = in_acc;
    assign lb_rd.col       = col_reg;
    assign lb_rd.col_right = COL_W'(col_reg + COL_W'(1));
    assign lb_wr.valid     = s1_valid_reg;
    assign lb_wr.col       = s1_col_reg;

    csib_line_buf u_line_buf
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (lb_rd),
        .pix   (pixel_in),
        .wb    (lb_wr),
        .above (lb_above),
        .up    (lb_up),
        .right (lb_right)
    );

    // center, up, down, left, right
    assign s1_sum = SUM_W'(lb_above) + SUM_W'(lb_up) + SUM_W'(s1_pix_reg)
                  + SUM_W'(left_above_reg) + SUM_W'(lb_right);

    assign div_prod = PROD_W'(SUM_W'(s2_sum_reg + SUM_W'(2))) * PROD_W'(DIV5_RECIP);
    assign s2_value = s2_interior_reg ? div_prod[DIV5_SHIFT +: PIX_W] : s2_above_reg;

    always_comb
    begin
        res_prev.row         = ROW_W'(s2_row_reg - ROW_W'(1));
        res_prev.col         = s2_col_reg;
        res_prev.value       = s2_value;
        res_prev.last_of_run = !s2_last_row_reg;
        res_prev.frame_end   = 1'b0;
        res_cur.row          = s2_row_reg;
        res_cur.col          = s2_col_reg;
        res_cur.value        = s2_pix_reg;
        res_cur.last_of_run  = 1'b1;
        res_cur.frame_end    = s2_last_col_reg;
    end

    assign push0    = s2_prev_reg ? res_prev : res_cur;
    assign push1    = res_cur;
    assign push_cnt = s2_valid_reg ? s2_n_reg : 2'd0;

    csib_res_fifo u_res_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (push1),
        .pop      (out_valid && out_ready),
        .head     (head),
        .count    (fifo_count)
    );

    assign out_valid   = (fifo_count != '0);
    assign out_row     = head.row;
    assign out_col     = head.col;
    assign out_value   = head.value;
    assign last_of_run = head.last_of_run;
    assign frame_end   = head.frame_end;

    // queue space held for items in flight always covers their results
    assert property (@(posedge clk) disable iff (!rst_n)
        reserved - (FIFO_CW+2)'(2) <= (FIFO_CW+2)'(FIFO_DEPTH))
        else $error("result queue reservation exceeded");

    // an item gives at most two results, and an empty slot carries none
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_n_reg != 2'd3) && (s2_valid_reg || (s2_n_reg == 2'd0)))
        else $error("result count in flight out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> last_of_run)
        else $error("frame end on a result that is not last of its run");

endmodule

@@ design/csib_line_buf.sv @@
// two line buffers (previous row and the row before it) in synchronous memories
// depends on csib_pkg; prior row written on accept, older row written back in the following cycle
`timescale 1ns / 1ps

module csib_line_buf
    import csib_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  csib_lb_rd_t      rd,
    input  logic [PIX_W-1:0] pix,
    input  csib_lb_wr_t      wb,
    output logic [PIX_W-1:0] above,
    output logic [PIX_W-1:0] up,
    output logic [PIX_W-1:0] right
);

    logic [PIX_W-1:0] prior_mem [MaxWidth];
    logic [PIX_W-1:0] older_mem [MaxWidth];

    logic [PIX_W-1:0] prior_rd0_reg;
    logic [PIX_W-1:0] prior_rd1_reg;
    logic [PIX_W-1:0] older_rd_reg;
    logic [PIX_W-1:0] fwd_data_reg;
    logic             fwd_reg;
    logic             fwd_next;

    always_ff @(posedge clk)
    begin
        if (rd.valid)
        begin
            prior_mem[rd.col] <= pix;
        end
        prior_rd0_reg <= prior_mem[rd.col];
        prior_rd1_reg <= prior_mem[rd.col_right];
        older_rd_reg  <= older_mem[rd.col];
        fwd_data_reg  <= prior_rd0_reg;
        if (wb.valid)
        begin
            older_mem[wb.col] <= prior_rd0_reg;
        end
    end

    // older row entry written back in the same cycle it is read
    assign fwd_next = wb.valid && (wb.col == rd.col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign above = prior_rd0_reg;
    assign right = prior_rd1_reg;
    assign up    = fwd_reg ? fwd_data_reg : older_rd_reg;

endmodule

@@ design/csib_res_fifo.sv @@
// result queue: up to two results pushed per cycle, one popped per cycle
// depends on csib_pkg for the result type and depth
`timescale 1ns / 1ps

module csib_res_fifo
    import csib_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_cnt,
    input  csib_result_t       push0,
    input  csib_result_t       push1,
    input  logic               pop,
    output csib_result_t       head,
    output logic [FIFO_CW-1:0] count
);

    csib_result_t entry_mem [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] wr_ptr_inc;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign wr_ptr_inc  = FIFO_AW'(wr_ptr_reg + FIFO_AW'(1));
    assign wr_ptr_next = FIFO_AW'(wr_ptr_reg + FIFO_AW'(push_cnt));
    assign rd_ptr_next = pop ? FIFO_AW'(rd_ptr_reg + FIFO_AW'(1)) : rd_ptr_reg;
    assign count_next  = FIFO_CW'(count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop));

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_mem[wr_ptr_inc] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = entry_mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

@@ tb/csib_blur_checker.sv @@
// checker for the cross stencil image blur core: predicts each result and compares
// depends on csib_pkg; watches the pixel, result and register channels of the block
`timescale 1ns / 1ps

module csib_blur_checker
    import csib_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [PIX_W-1:0] pixel_in,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [ROW_W-1:0] out_row,
    input  logic [COL_W-1:0] out_col,
    input  logic [PIX_W-1:0] out_value,
    input  logic             last_of_run,
    input  logic             frame_end,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               pending,
    output int               errors
);

    localparam int CrossTaps = 5;

    logic [CFG_W-1:0] size_cols;
    logic [CFG_W-1:0] size_rows;
    logic [PIX_W-1:0] row_older [MaxWidth];
    logic [PIX_W-1:0] row_prev  [MaxWidth];
    int               cur_row;
    int               cur_col;
    int               mismatches = 0;
    csib_result_t     due_px [$];

    function automatic int frame_dim(input logic [CFG_W-1:0] raw, input int limit);
        if (raw == '0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic blur_step(input logic [PIX_W-1:0] pix);
        int               w;
        int               h;
        int               r;
        int               c;
        int               acc;
        logic [PIX_W-1:0] north;
        logic             bottom;
        logic             right_edge;
        csib_result_t     res;
        w = frame_dim(size_cols, MaxWidth);
        h = frame_dim(size_rows, MaxHeight);
        r = cur_row;
        c = cur_col;
        if (r >= h || c >= w)
        begin
            r = 0;
            c = 0;
        end
        bottom     = (r + 1 == h);
        right_edge = (c + 1 == w);
        north      = row_prev[c];
        // the row above is complete once the pixel below it arrives
        if (r >= 1)
        begin
            res.row   = ROW_W'(r - 1);
            res.col   = COL_W'(c);
            res.value = north;
            if (r >= 2 && c >= 1 && c + 1 < w)
            begin
                acc = int'(north) + int'(row_older[c]) + int'(pix)
                    + int'(row_older[c - 1]) + int'(row_prev[c + 1]);
                res.value = PIX_W'((acc + 2) / CrossTaps);
            end
            res.last_of_run = !bottom;
            res.frame_end   = 1'b0;
            due_px.push_back(res);
        end
        // bottom row pixels are border pixels and leave at once
        if (bottom)
        begin
            res.row         = ROW_W'(r);
            res.col         = COL_W'(c);
            res.value       = pix;
            res.last_of_run = 1'b1;
            res.frame_end   = right_edge;
            due_px.push_back(res);
        end
        row_older[c] = north;
        row_prev[c]  = pix;
        if (right_edge)
        begin
            cur_col = 0;
            cur_row = bottom ? 0 : r + 1;
        end
        else
        begin
            cur_col = c + 1;
            cur_row = r;
        end
    endtask

    task automatic check_result();
        csib_result_t want;
        if (due_px.size() == 0)
        begin
            log_mismatch($sformatf("unexpected item row %0d col %0d value %0d",
                                   out_row, out_col, out_value));
            return;
        end
        want = due_px.pop_front();
        if (out_row !== want.row)
            log_mismatch($sformatf("pixel (%0d,%0d): row %0d", want.row, want.col, out_row));
        if (out_col !== want.col)
            log_mismatch($sformatf("pixel (%0d,%0d): col %0d", want.row, want.col, out_col));
        if (out_value !== want.value)
            log_mismatch($sformatf("pixel (%0d,%0d): value %0d, expected %0d",
                                   want.row, want.col, out_value, want.value));
        if (last_of_run !== want.last_of_run)
            log_mismatch($sformatf("pixel (%0d,%0d): last_of_run %b, expected %b",
                                   want.row, want.col, last_of_run, want.last_of_run));
        if (frame_end !== want.frame_end)
            log_mismatch($sformatf("pixel (%0d,%0d): frame_end %b, expected %b",
                                   want.row, want.col, frame_end, want.frame_end));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cols = CFG_W'(MaxWidth);
            size_rows = CFG_W'(MaxHeight);
            cur_row   = 0;
            cur_col   = 0;
            for (int k = 0; k < MaxWidth; k++)
            begin
                row_older[k] = '0;
                row_prev[k]  = '0;
            end
            due_px.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                // any register write restarts the frame; unknown indexes are dropped
                if (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT)
                begin
                    if (cfg_index == CFG_IDX_WIDTH)
                        size_cols = cfg_data;
                    else
                        size_rows = cfg_data;
                    cur_row = 0;
                    cur_col = 0;
                end
            end
            if (in_valid && in_ready)
                blur_step(pixel_in);
        end
        pending <= due_px.size();
        errors  <= mismatches;
    end

endmodule

@@ tb/cross_stencil_image_blur_core_test.sv @@
// top of the cross stencil image blur core test: clock, reset, stimulus and verdict
// depends on csib_pkg, cross_stencil_image_blur_core and csib_blur_checker
`timescale 1ns / 1ps

module cross_stencil_image_blur_core_test;
    import csib_pkg::*;

    localparam int HoldCycles   = 300;
    localparam int SettleCycles = 10;
    localparam int EndCycles    = 20;
    localparam int TargetItems  = 950;
    localparam int IdlePct      = 31;

    typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_FLAT} pix_style_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [PIX_W-1:0] pixel_in  = '0;
    logic             out_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_ready;
    logic             out_valid;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] out_value;
    logic             last_of_run;
    logic             frame_end;
    logic             cfg_ready;

    logic sink_hold     = 1'b0;
    int   src_idle_pct  = IdlePct;
    int   sink_idle_pct = IdlePct;
    int   items_sent    = 0;
    int   pending;
    int   errors;

    always #10 clk = ~clk;

    cross_stencil_image_blur_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    csib_blur_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .last_of_run (last_of_run),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pending     (pending),
        .errors      (errors)
    );

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold)
            begin
                out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                sink_hold <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [CFG_W-1:0] size_code(input int n, input int limit);
        if (n == 1 && $urandom_range(1) == 1)
            return '0;
        if (n == limit && $urandom_range(1) == 1)
            return CFG_W'($urandom_range(limit + 1, 255));
        return CFG_W'(n);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        // occasionally a write to an unused index, which the block drops
        if ($urandom_range(5) == 0)
            write_reg(CFG_IDX_HEIGHT + IDX_W'($urandom_range(1, 254)), CFG_W'($urandom));
        write_reg(CFG_IDX_WIDTH, size_code(w, MaxWidth));
        write_reg(CFG_IDX_HEIGHT, size_code(h, MaxHeight));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic feed_pixel(input logic [PIX_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic stream_pixels(input int count, input pix_style_t style,
                                 input logic [PIX_W-1:0] level, input int pause_at);
        logic [PIX_W-1:0] value;
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
                wait_drained();
            case (style)
                PIX_RANDOM:  value = PIX_W'($urandom_range(255));
                PIX_EXTREME: value = ($urandom_range(1) == 1) ? '1 : '0;
                default:     value = level;
            endcase
            feed_pixel(value);
        end
    endtask

    initial
    begin
        int         phase;
        int         sel;
        int         w;
        int         h;
        int         count;
        int         pause_at;
        pix_style_t style;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full-scale and zero interiors over two wrapped frames
        write_reg(CFG_IDX_WIDTH, CFG_W'(3));
        write_reg(CFG_IDX_HEIGHT, CFG_W'(3));
        stream_pixels(9, PIX_FLAT, '1, -1);
        stream_pixels(9, PIX_FLAT, '0, -1);
        wait_drained();
        // unused index, then zero sizes acting as a single pixel frame
        write_reg('1, CFG_W'(2));
        write_reg(CFG_IDX_WIDTH, '0);
        write_reg(CFG_IDX_HEIGHT, '0);
        stream_pixels(1, PIX_RANDOM, '0, -1);
        wait_drained();
        // single row frame: every pixel leaves at once
        write_reg(CFG_IDX_WIDTH, CFG_W'(4));
        write_reg(CFG_IDX_HEIGHT, CFG_W'(1));
        stream_pixels(4, PIX_EXTREME, '0, -1);
        wait_drained();

        phase = 0;
        while (items_sent < TargetItems)
        begin
            sel = $urandom_range(15);
            if (phase == 0 || sel == 0)
            begin
                w = MaxWidth;
                h = $urandom_range(2, 3);
            end
            else if (sel == 1)
            begin
                w = $urandom_range(1, 2);
                h = MaxHeight;
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
            count = w * h;
            if (count <= 64)
                count = count * $urandom_range(1, 3);
            if (count > 1 && $urandom_range(9) == 0)
                count = $urandom_range(1, count - 1);
            pause_at = -1;
            if (phase == 0)
                pause_at = count / 2;
            else if ($urandom_range(7) == 0)
                pause_at = $urandom_range(count - 1);
            style = ($urandom_range(4) == 0) ? PIX_EXTREME : PIX_RANDOM;

            if (phase >= 4 && phase < 10)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            else
            begin
                src_idle_pct  = IdlePct;
                sink_idle_pct = IdlePct;
            end

            set_frame(w, h);
            if (phase == 0 || $urandom_range(19) == 0)
            begin
                while (sink_hold) @(posedge clk);
                sink_hold <= 1'b1;
            end
            stream_pixels(count, style, '0, pause_at);
            wait_drained();
            phase++;
        end

        wait_drained();
        repeat (EndCycles) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("cross_stencil_image_blur_core_test passed");
        else
            $display("cross_stencil_image_blur_core_test failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("cross_stencil_image_blur_core_test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/csib_pkg.sv
design/csib_line_buf.sv
design/csib_res_fifo.sv
design/cross_stencil_image_blur_core.sv
tb/csib_blur_checker.sv
tb/cross_stencil_image_blur_core_test.sv
